// ===== src/bspa_pkg.sv =====
// ----------------------------------------------------------------------------
// bspa_pkg: shared types and constants for the bitmap slot pool allocator
// Item layouts, command and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package bspa_pkg;

    localparam int unsigned DEF_MAX_SLOTS = 1024;
    localparam int unsigned ADDR_W        = 32;
    localparam int unsigned BYTES_W       = 24;
    localparam int unsigned SZ_W          = 13;
    localparam int unsigned SLOTS_W       = 11;
    localparam int unsigned USED_W        = 23;
    localparam int unsigned NEED_W        = BYTES_W + 1;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned SZ_MAX        = 4096;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_OWNS  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_RUN   = 3'd1,
        ST_OUTSIDE  = 3'd2,
        ST_NOT_TAKEN = 3'd3,
        ST_PAST_END = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE  = 2'd0,
        CFG_SLOT_BYTES = 2'd1,
        CFG_SLOTS      = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [BYTES_W-1:0] req_len;
        logic [ADDR_W-1:0]  address;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] granted_address;
        logic              owned;
        logic [USED_W-1:0] held_bytes;
    } out_item_t;

    typedef struct packed {
        logic    ld;
        logic    div_go;
        logic    div_sel;     // 1: address offset, 0: byte count
        logic    ptr_zero;
        logic    ptr_base;
        logic    ptr_inc;
        logic    base_start;
        logic    run_clr;
        logic    run_inc;
        logic    mem_rd;
        logic    mem_wr;
        logic    wr_val;
        logic    cnt_clr;
        logic    cnt_add;
        logic    cnt_sub;
        logic    st_ld;
        status_t st_val;
        logic    alloc_ok;
        logic    res_ld;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic div_done;
        logic in_pool;
        logic need_zero;
        logic past_end;
        logic map_bit;
        logic ptr_at_cap;
        logic run_hit;
        logic seg_last;
        logic clr_last;
    } dp_stat_t;

endpackage

// ===== src/bspa_div.sv =====
// ----------------------------------------------------------------------------
// bspa_div: restoring divider, one quotient bit per cycle
// Divides a 32-bit value by a slot size; reports quotient and inexact flag.
// ----------------------------------------------------------------------------
module bspa_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [bspa_pkg::ADDR_W-1:0] dividend,
    input  logic [bspa_pkg::SZ_W-1:0]   divisor,
    output logic                        done,
    output logic [bspa_pkg::ADDR_W-1:0] quot,
    output logic                        inexact
);
    import bspa_pkg::*;

    localparam int unsigned STEP_W = $clog2(ADDR_W + 1);

    logic [SZ_W:0]       rem_reg, rem_next;
    logic [ADDR_W-1:0]   q_reg, q_next;
    logic [SZ_W-1:0]     dvs_reg;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [SZ_W:0]       trial;

    always_comb
    begin
        trial     = {rem_reg[SZ_W-1:0], q_reg[ADDR_W-1]};
        rem_next  = rem_reg;
        q_next    = q_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            rem_next  = '0;
            q_next    = dividend;
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                q_next   = {q_reg[ADDR_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[ADDR_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ADDR_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (go)
            dvs_reg <= divisor;
    end

    assign done    = done_reg;
    assign quot    = q_reg;
    assign inexact = (rem_reg != '0);

endmodule

// ===== src/bspa_dp.sv =====
// ----------------------------------------------------------------------------
// bspa_dp: allocator datapath
// Config registers, slot map memory, pointers, counters and result register.
// ----------------------------------------------------------------------------
module bspa_dp #(
    parameter int unsigned MAX_SLOTS = bspa_pkg::DEF_MAX_SLOTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bspa_pkg::dp_cmd_t              dcmd,
    output bspa_pkg::dp_stat_t             dstat,
    input  bspa_pkg::in_item_t             cmd_item,
    input  logic                           cfg_we,
    input  logic [bspa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bspa_pkg::ADDR_W-1:0]    cfg_data,
    output bspa_pkg::out_item_t            result
);
    import bspa_pkg::*;

    localparam int unsigned IW = $clog2(MAX_SLOTS);
    localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
    localparam int unsigned PW = CW + SZ_W;
    localparam int unsigned SW = (CW > NEED_W ? CW : NEED_W) + 1;

    logic [ADDR_W-1:0]  base_cfg_reg;
    logic [SZ_W-1:0]    sz_cfg_reg;
    logic [SLOTS_W-1:0] slots_cfg_reg;

    logic [SZ_W-1:0]    sz_eff;
    logic [CW-1:0]      cap_eff;
    logic [ADDR_W:0]    end_reg;

    in_item_t           item_reg;
    logic [NEED_W-1:0]  need_reg;
    logic [CW-1:0]      base_reg;
    logic [CW-1:0]      ptr_reg;
    logic [CW-1:0]      run_reg;
    logic [CW-1:0]      cnt_reg;
    status_t            st_reg;
    logic               ok_reg;
    out_item_t          res_reg;

    logic               map_mem [MAX_SLOTS];
    logic               rd_reg;

    logic               div_sel_reg;
    logic               div_done;
    logic [ADDR_W-1:0]  div_q;
    logic               div_inexact;
    logic [ADDR_W-1:0]  offset;
    logic [ADDR_W-1:0]  div_in;
    logic               in_pool;
    logic [SW-1:0]      seg_end;
    logic [CW-1:0]      start_idx;
    logic [PW-1:0]      used_prod;
    logic [PW-1:0]      grant_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cfg_reg  <= '0;
            sz_cfg_reg    <= SZ_W'(64);
            slots_cfg_reg <= SLOTS_W'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_POOL_BASE:  base_cfg_reg  <= cfg_data;
                CFG_SLOT_BYTES: sz_cfg_reg    <= cfg_data[SZ_W-1:0];
                CFG_SLOTS:      slots_cfg_reg <= cfg_data[SLOTS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (sz_cfg_reg == '0)
            sz_eff = SZ_W'(1);
        else if (sz_cfg_reg > SZ_W'(SZ_MAX))
            sz_eff = SZ_W'(SZ_MAX);
        else
            sz_eff = sz_cfg_reg;
        if (32'(slots_cfg_reg) > 32'(MAX_SLOTS))
            cap_eff = CW'(MAX_SLOTS);
        else
            cap_eff = CW'(slots_cfg_reg);
    end

    always_ff @(posedge clk)
    begin
        end_reg <= {1'b0, base_cfg_reg} + (ADDR_W+1)'(PW'(cap_eff) * PW'(sz_eff));
    end

    assign offset = item_reg.address - base_cfg_reg;
    assign div_in = dcmd.div_sel ? offset : ADDR_W'(item_reg.req_len);
    assign in_pool = ({1'b0, item_reg.address} >= {1'b0, base_cfg_reg})
                  && ({1'b0, item_reg.address} < end_reg);

    bspa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (dcmd.div_go),
        .dividend (div_in),
        .divisor  (sz_eff),
        .done     (div_done),
        .quot     (div_q),
        .inexact  (div_inexact)
    );

    assign seg_end   = SW'(base_reg) + SW'(need_reg);
    assign start_idx = CW'(SW'(ptr_reg) + SW'(1) - SW'(need_reg));

    always_ff @(posedge clk)
    begin
        if (dcmd.ld)
            item_reg <= cmd_item;
        if (dcmd.div_go)
            div_sel_reg <= dcmd.div_sel;
        if (div_done)
        begin
            if (div_sel_reg)
                base_reg <= div_q[CW-1:0];
            else
                need_reg <= NEED_W'(div_q[BYTES_W-1:0]) + NEED_W'(div_inexact);
        end
        if (dcmd.base_start)
            base_reg <= start_idx;
        if (dcmd.run_clr)
            run_reg <= '0;
        else if (dcmd.run_inc)
            run_reg <= run_reg + 1'b1;
        if (dcmd.ld)
        begin
            st_reg <= ST_OK;
            ok_reg <= 1'b0;
        end
        else
        begin
            if (dcmd.st_ld)
                st_reg <= dcmd.st_val;
            if (dcmd.alloc_ok)
                ok_reg <= 1'b1;
        end
        if (dcmd.res_ld)
        begin
            res_reg.status          <= st_reg;
            res_reg.granted_address <= ok_reg ? base_cfg_reg + ADDR_W'(grant_prod) : '0;
            res_reg.owned           <= in_pool;
            res_reg.held_bytes      <= used_prod[USED_W-1:0];
        end
    end

    assign used_prod  = PW'(cnt_reg) * PW'(sz_eff);
    assign grant_prod = PW'(base_reg) * PW'(sz_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (dcmd.ptr_zero)
                ptr_reg <= '0;
            else if (dcmd.base_start)
                ptr_reg <= start_idx;
            else if (dcmd.ptr_base)
                ptr_reg <= base_reg;
            else if (dcmd.ptr_inc)
                ptr_reg <= ptr_reg + 1'b1;
            if (dcmd.cnt_clr)
                cnt_reg <= '0;
            else if (dcmd.cnt_add)
                cnt_reg <= cnt_reg + CW'(need_reg);
            else if (dcmd.cnt_sub)
                cnt_reg <= cnt_reg - CW'(need_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.mem_wr)
            map_mem[ptr_reg[IW-1:0]] <= dcmd.wr_val;
        if (dcmd.mem_rd)
            rd_reg <= map_mem[ptr_reg[IW-1:0]];
    end

    always_comb
    begin
        dstat.cmd        = cmd_t'(item_reg.cmd);
        dstat.div_done   = div_done;
        dstat.in_pool    = in_pool;
        dstat.need_zero  = (need_reg == '0);
        dstat.past_end   = (seg_end > SW'(cap_eff));
        dstat.map_bit    = rd_reg;
        dstat.ptr_at_cap = (ptr_reg == cap_eff);
        dstat.run_hit    = (SW'(run_reg) + SW'(1) == SW'(need_reg));
        dstat.seg_last   = (SW'(ptr_reg) + SW'(1) == seg_end);
        dstat.clr_last   = (ptr_reg == CW'(MAX_SLOTS - 1));
    end

    assign result = res_reg;

endmodule

// ===== src/bspa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bspa_ctrl: allocator sequencer
// One-hot state machine driving the datapath through each command.
// ----------------------------------------------------------------------------
module bspa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output bspa_pkg::dp_cmd_t  dcmd,
    input  bspa_pkg::dp_stat_t dstat
);
    import bspa_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_PREP  = 16'h0002,
        S_CLR   = 16'h0004,
        S_ADIV  = 16'h0008,
        S_ACHK  = 16'h0010,
        S_ARD   = 16'h0020,
        S_ATST  = 16'h0040,
        S_AWR   = 16'h0080,
        S_FDIV1 = 16'h0100,
        S_FDIV2 = 16'h0200,
        S_FCHK  = 16'h0400,
        S_FRD   = 16'h0800,
        S_FTST  = 16'h1000,
        S_FWR   = 16'h2000,
        S_RES   = 16'h4000,
        S_OUT   = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   clr_item_reg, clr_item_next;

    always_comb
    begin
        state_next    = state_reg;
        clr_item_next = clr_item_reg;
        dcmd          = '0;
        dcmd.st_val   = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    dcmd.ld    = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                case (dstat.cmd)
                    CMD_ALLOC:
                    begin
                        dcmd.div_go = 1'b1;
                        state_next  = S_ADIV;
                    end
                    CMD_FREE:
                    begin
                        if (!dstat.in_pool)
                        begin
                            dcmd.st_ld  = 1'b1;
                            dcmd.st_val = ST_OUTSIDE;
                            state_next  = S_RES;
                        end
                        else
                        begin
                            dcmd.div_go  = 1'b1;
                            dcmd.div_sel = 1'b1;
                            state_next   = S_FDIV1;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        dcmd.ptr_zero = 1'b1;
                        dcmd.cnt_clr  = 1'b1;
                        clr_item_next = 1'b1;
                        state_next    = S_CLR;
                    end
                    default:
                        state_next = S_RES;
                endcase
            end
            S_CLR:
            begin
                dcmd.mem_wr  = 1'b1;
                dcmd.ptr_inc = 1'b1;
                if (dstat.clr_last)
                begin
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? S_RES : S_IDLE;
                end
            end
            S_ADIV:
            begin
                if (dstat.div_done)
                    state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (dstat.need_zero)
                begin
                    dcmd.st_ld  = 1'b1;
                    dcmd.st_val = ST_NO_RUN;
                    state_next  = S_RES;
                end
                else
                begin
                    dcmd.ptr_zero = 1'b1;
                    dcmd.run_clr  = 1'b1;
                    state_next    = S_ARD;
                end
            end
            S_ARD:
            begin
                if (dstat.ptr_at_cap)
                begin
                    dcmd.st_ld  = 1'b1;
                    dcmd.st_val = ST_NO_RUN;
                    state_next  = S_RES;
                end
                else
                begin
                    dcmd.mem_rd = 1'b1;
                    state_next  = S_ATST;
                end
            end
            S_ATST:
            begin
                if (dstat.map_bit)
                begin
                    dcmd.run_clr = 1'b1;
                    dcmd.ptr_inc = 1'b1;
                    state_next   = S_ARD;
                end
                else if (dstat.run_hit)
                begin
                    dcmd.base_start = 1'b1;
                    state_next      = S_AWR;
                end
                else
                begin
                    dcmd.run_inc = 1'b1;
                    dcmd.ptr_inc = 1'b1;
                    state_next   = S_ARD;
                end
            end
            S_AWR:
            begin
                dcmd.mem_wr  = 1'b1;
                dcmd.wr_val  = 1'b1;
                dcmd.ptr_inc = 1'b1;
                if (dstat.seg_last)
                begin
                    dcmd.cnt_add  = 1'b1;
                    dcmd.alloc_ok = 1'b1;
                    state_next    = S_RES;
                end
            end
            S_FDIV1:
            begin
                if (dstat.div_done)
                begin
                    dcmd.div_go = 1'b1;
                    state_next  = S_FDIV2;
                end
            end
            S_FDIV2:
            begin
                if (dstat.div_done)
                    state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (dstat.past_end)
                begin
                    dcmd.st_ld  = 1'b1;
                    dcmd.st_val = ST_PAST_END;
                    state_next  = S_RES;
                end
                else if (dstat.need_zero)
                    state_next = S_RES;
                else
                begin
                    dcmd.ptr_base = 1'b1;
                    state_next    = S_FRD;
                end
            end
            S_FRD:
            begin
                dcmd.mem_rd = 1'b1;
                state_next  = S_FTST;
            end
            S_FTST:
            begin
                if (!dstat.map_bit)
                begin
                    dcmd.st_ld  = 1'b1;
                    dcmd.st_val = ST_NOT_TAKEN;
                    state_next  = S_RES;
                end
                else if (dstat.seg_last)
                begin
                    dcmd.ptr_base = 1'b1;
                    state_next    = S_FWR;
                end
                else
                begin
                    dcmd.ptr_inc = 1'b1;
                    state_next   = S_FRD;
                end
            end
            S_FWR:
            begin
                dcmd.mem_wr  = 1'b1;
                dcmd.ptr_inc = 1'b1;
                if (dstat.seg_last)
                begin
                    dcmd.cnt_sub = 1'b1;
                    state_next   = S_RES;
                end
            end
            S_RES:
            begin
                dcmd.res_ld = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_item_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_item_reg <= clr_item_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

endmodule

// ===== src/bitmap_slot_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_slot_pool_allocator: first-fit slot allocator over a bitmap
// Alloc, free, owns and clear commands on a pool of equal-sized slots.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------
//   command  | start / busy       | cmd_item  (cmd, req_len, address)
//   result   | done (1-cycle)     | result    (status, granted_address,
//            |                    |            owned, held_bytes)
//   config   | cfg_we             | cfg_index, cfg_data
//
// One item at a time; busy drops in the cycle after the done cycle. Owns, or
// free outside the pool, goes straight to the result. Alloc divides the
// byte count by the slot size, scans the map, then marks the granted run.
// Free divides the offset, then the byte count, checks each slot of the run
// and clears it. Clear sweeps the whole map. After reset the map is swept
// clear with busy high. done pulses one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module bitmap_slot_pool_allocator #(
    parameter int unsigned MAX_SLOTS = bspa_pkg::DEF_MAX_SLOTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bspa_pkg::in_item_t             cmd_item,
    output logic                           done,
    output bspa_pkg::out_item_t            result,
    input  logic                           cfg_we,
    input  logic [bspa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bspa_pkg::ADDR_W-1:0]    cfg_data
);
    import bspa_pkg::*;

    dp_cmd_t  dcmd;
    dp_stat_t dstat;

    bspa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .dcmd  (dcmd),
        .dstat (dstat)
    );

    bspa_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dcmd      (dcmd),
        .dstat     (dstat),
        .cmd_item  (cmd_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bitmap_slot_pool_allocator
// Directed and random alloc/free/owns/clear items against a bitmap predictor,
// under several pool settings and sender idle mixes. Results are compared
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bspa_pkg::*;

    localparam int unsigned NSLOTS = DEF_MAX_SLOTS;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    in_item_t             cmd_item = '0;
    logic                 done;
    out_item_t            result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data = '0;

    bitmap_slot_pool_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd_item  (cmd_item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // predictor state
    logic [31:0]       base_reg;
    logic [12:0]       size_reg;
    logic [10:0]       count_reg;
    bit                taken_map [NSLOTS];
    int unsigned       taken_total;

    in_item_t          pending_items [$];
    out_item_t         expected_results [$];
    int unsigned       error_count = 0;
    int unsigned       idle_pct = 0;
    int unsigned       accepted_count = 0;
    // granted runs for well-formed frees
    logic [31:0]       grant_addr_q [$];
    logic [23:0]       grant_len_q [$];

    function automatic int unsigned slots_needed(int unsigned bytes, int unsigned sz);
        return bytes / sz + ((bytes % sz) != 0 ? 1 : 0);
    endfunction

    function automatic out_item_t apply_command(in_item_t it);
        out_item_t   r;
        int unsigned sz;
        int unsigned cap;
        longint unsigned pool_end;
        bit          in_pool;
        int unsigned need;
        int unsigned run;
        int unsigned first;
        int unsigned idx;
        bit          found;
        sz = (size_reg == 0) ? 1 : ((size_reg > SZ_MAX) ? SZ_MAX : size_reg);
        cap = (count_reg > NSLOTS) ? NSLOTS : count_reg;
        pool_end = longint'(base_reg) + longint'(cap) * sz;
        in_pool = (longint'(it.address) >= longint'(base_reg)) &&
                  (longint'(it.address) < pool_end);
        r = '0;
        r.status = ST_OK;
        case (cmd_t'(it.cmd))
            CMD_ALLOC:
            begin
                need = slots_needed(32'(it.req_len), sz);
                run = 0;
                found = 1'b0;
                first = 0;
                if (need != 0)
                begin
                    for (int unsigned i = 0; i < cap; i++)
                    begin
                        if (taken_map[i])
                            run = 0;
                        else
                        begin
                            run++;
                            if (run == need)
                            begin
                                first = i + 1 - need;
                                found = 1'b1;
                                break;
                            end
                        end
                    end
                end
                if (found)
                begin
                    for (int unsigned i = first; i < first + need; i++)
                        taken_map[i] = 1'b1;
                    taken_total += need;
                    r.granted_address = base_reg + first * sz;
                    grant_addr_q.push_back(r.granted_address);
                    grant_len_q.push_back(it.req_len);
                end
                else
                    r.status = ST_NO_RUN;
            end
            CMD_FREE:
            begin
                if (!in_pool)
                    r.status = ST_OUTSIDE;
                else
                begin
                    idx = (it.address - base_reg) / sz;
                    need = slots_needed(32'(it.req_len), sz);
                    if (longint'(idx) + need > cap)
                        r.status = ST_PAST_END;
                    else
                    begin
                        for (int unsigned i = idx; i < idx + need; i++)
                            if (!taken_map[i])
                            begin
                                r.status = ST_NOT_TAKEN;
                                break;
                            end
                        if (r.status == ST_OK)
                        begin
                            for (int unsigned i = idx; i < idx + need; i++)
                                taken_map[i] = 1'b0;
                            taken_total -= need;
                        end
                    end
                end
            end
            CMD_CLEAR:
            begin
                foreach (taken_map[i])
                    taken_map[i] = 1'b0;
                taken_total = 0;
                grant_addr_q.delete();
                grant_len_q.delete();
            end
            default:
            begin
            end
        endcase
        r.owned = in_pool;
        r.held_bytes = USED_W'(longint'(taken_total) * sz);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            expected_results.push_back(apply_command(cmd_item));
            accepted_count++;
        end
        if (start && busy)
        begin
            // hold current item
        end
        else if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            start <= 1'b1;
            cmd_item <= pending_items.pop_front();
        end
        else
            start <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t w;
        if (done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 64'(result), 64'd0);
            else
            begin
                w = expected_results.pop_front();
                if (result.status !== w.status)
                    report_mismatch("status", 64'(result.status), 64'(w.status));
                if (result.granted_address !== w.granted_address)
                    report_mismatch("granted_address", 64'(result.granted_address),
                                    64'(w.granted_address));
                if (result.owned !== w.owned)
                    report_mismatch("owned", 64'(result.owned), 64'(w.owned));
                if (result.held_bytes !== w.held_bytes)
                    report_mismatch("held_bytes", 64'(result.held_bytes),
                                    64'(w.held_bytes));
            end
        end
    end

    task automatic push_item(cmd_t c, logic [31:0] n, logic [31:0] a);
        in_item_t it;
        it.cmd = c;
        it.req_len = n[BYTES_W-1:0];
        it.address = a;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || start || busy || expected_results.size() > 0)
            @(posedge clk);
        repeat (NSLOTS + 200) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_POOL_BASE:  base_reg = val;
            CFG_SLOT_BYTES: size_reg = val[12:0];
            default:        count_reg = val[10:0];
        endcase
    endtask

    // mostly sized to the current pool, with occasional full-range noise
    task automatic random_items(int unsigned n);
        int unsigned sz;
        int unsigned span;
        int unsigned k;
        logic [31:0] a;
        sz = (size_reg == 0) ? 1 : ((size_reg > SZ_MAX) ? SZ_MAX : size_reg);
        span = ((count_reg > NSLOTS) ? NSLOTS : count_reg) * sz;
        for (int unsigned i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            a = base_reg + $urandom_range(span + sz);
            if (k < 40)
                push_item(CMD_ALLOC, $urandom_range(8 * sz), $urandom);
            else if (k < 70 && grant_addr_q.size() > 0)
            begin
                push_item(CMD_FREE, 32'(grant_len_q[0]), grant_addr_q[0]);
                grant_addr_q.pop_front();
                grant_len_q.pop_front();
            end
            else if (k < 80)
                push_item(CMD_FREE, $urandom_range(4 * sz), a);
            else if (k < 88)
                push_item(CMD_OWNS, $urandom, a);
            else if (k < 90)
                push_item(CMD_CLEAR, $urandom, $urandom);
            else
                push_item(cmd_t'($urandom_range(3)), $urandom, $urandom);
            // predicted grants only exist after acceptance; keep queue shallow
            while (pending_items.size() > 4)
                @(posedge clk);
        end
    endtask

    initial
    begin
        base_reg = '0;
        size_reg = 13'd64;
        count_reg = 11'd1024;
        foreach (taken_map[i])
            taken_map[i] = 1'b0;
        taken_total = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset configuration
        push_item(CMD_ALLOC, 0, 0);
        push_item(CMD_ALLOC, 1, 32'hFFFF_FFFF);
        push_item(CMD_ALLOC, 130, 0);
        push_item(CMD_OWNS, 0, 65535);
        push_item(CMD_OWNS, 0, 65536);
        push_item(CMD_OWNS, 32'hFF_FFFF, 32'hFFFF_FFFF);
        push_item(CMD_FREE, 64, 70);
        push_item(CMD_FREE, 64, 70);
        push_item(CMD_FREE, 0, 100);
        push_item(CMD_FREE, 64, 65536);
        push_item(CMD_FREE, 128, 65472);
        push_item(CMD_ALLOC, 32'hFF_FFFF, 0);
        push_item(CMD_ALLOC, 65536, 0);
        push_item(CMD_ALLOC, 1, 0);
        push_item(CMD_FREE, 64, 128);
        push_item(CMD_CLEAR, 32'hFF_FFFF, 32'hFFFF_FFFF);
        push_item(CMD_ALLOC, 65536, 0);
        push_item(CMD_FREE, 65536, 0);
        drain();

        // extremes: tiny slots near the top of the address space, zero slot size
        write_reg(CFG_POOL_BASE, 32'hFFFF_FF00);
        write_reg(CFG_SLOT_BYTES, 0);
        write_reg(CFG_SLOTS, 32'h7FF);
        push_item(CMD_ALLOC, 300, 0);
        push_item(CMD_OWNS, 0, 32'hFFFF_FFFF);
        push_item(CMD_OWNS, 0, 32'hFFFF_FEFF);
        push_item(CMD_FREE, 1, 32'hFFFF_FF05);
        drain();
        write_reg(CFG_SLOTS, 0);
        push_item(CMD_ALLOC, 1, 0);
        push_item(CMD_OWNS, 0, 32'hFFFF_FF00);
        push_item(CMD_FREE, 1, 32'hFFFF_FF00);
        drain();

        idle_pct = 0;
        write_reg(CFG_POOL_BASE, $urandom);
        write_reg(CFG_SLOT_BYTES, 32'h1FFF);
        write_reg(CFG_SLOTS, 1);
        random_items(40);
        drain();

        idle_pct = 66;
        write_reg(CFG_POOL_BASE, 32'h1000);
        write_reg(CFG_SLOT_BYTES, 4096);
        write_reg(CFG_SLOTS, 3);
        random_items(60);
        drain();

        idle_pct = 26;
        write_reg(CFG_POOL_BASE, $urandom);
        write_reg(CFG_SLOT_BYTES, $urandom_range(1, 100));
        write_reg(CFG_SLOTS, $urandom_range(1, 24));
        random_items(200);
        drain();

        idle_pct = 0;
        write_reg(CFG_POOL_BASE, 0);
        write_reg(CFG_SLOT_BYTES, 1);
        write_reg(CFG_SLOTS, 16);
        random_items(130);
        drain();

        idle_pct = 66;
        write_reg(CFG_SLOT_BYTES, $urandom_range(1, 4096));
        write_reg(CFG_SLOTS, 8);
        random_items(100);
        drain();

        if (error_count == 0)
            $display("** bitmap_slot_pool_allocator: PASSED **");
        else
            $display("** bitmap_slot_pool_allocator: FAILED **");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("** bitmap_slot_pool_allocator: FAILED **");
        $finish;
    end
endmodule
